[sv/ezr_pkg.sv]
// Shared types, constants and arithmetic helpers for the Euler ZYX to rotation matrix core.
// Used by every module of the core; no dependencies of its own.
`default_nettype none
package ezr_pkg;

  localparam int AngleFracBits = 13;
  localparam int OutFracBits   = 14;
  localparam int CordicStages  = 16;

  localparam int QFrac = 30;
  localparam int CW    = 35;

  typedef logic signed [CW-1:0] q_t;

  localparam q_t QPi     = 35'sd3373259426;
  localparam q_t QHalfPi = 35'sd1686629713;
  localparam q_t QTwoPi  = 35'sd6746518852;
  localparam q_t QGain   = 35'sd652032874;
  localparam q_t QOne    = 35'sd1073741824;

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic flip;
  } lane_t;

  typedef struct packed {
    lane_t [2:0] lane;
    logic        rate;
  } item_t;

  typedef q_t [17:0] mat_t;

  function automatic q_t atan_q30(input int i);
    q_t a;
    case (i)
      0:  a = 35'sh03243F6A8;
      1:  a = 35'sh01DAC6705;
      2:  a = 35'sh00FADBAFC;
      3:  a = 35'sh007F56EA6;
      4:  a = 35'sh003FEAB76;
      5:  a = 35'sh001FFD55B;
      6:  a = 35'sh000FFFAAA;
      7:  a = 35'sh0007FFF55;
      8:  a = 35'sh0003FFFEA;
      9:  a = 35'sh0001FFFFD;
      10: a = 35'sh0000FFFFF;
      11: a = 35'sh00007FFFF;
      12: a = 35'sh00003FFFF;
      13: a = 35'sh00001FFFF;
      14: a = 35'sh00000FFFF;
      15: a = 35'sh000007FFF;
      16: a = 35'sh000003FFF;
      17: a = 35'sh000001FFF;
      18: a = 35'sh000000FFF;
      19: a = 35'sh0000007FF;
      20: a = 35'sh0000003FF;
      21: a = 35'sh0000001FF;
      22: a = 35'sh0000000FF;
      23: a = 35'sh00000007F;
      24: a = 35'sh00000003F;
      25: a = 35'sh00000001F;
      26: a = 35'sh00000000F;
      27: a = 35'sh000000008;
      28: a = 35'sh000000004;
      29: a = 35'sh000000002;
      30: a = 35'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [2*CW-1:0] p;
    p = a * b + (70'sd1 <<< (QFrac - 1));
    return q_t'(p >>> QFrac);
  endfunction

endpackage
`default_nettype wire

[sv/ezr_reduce.sv]
// Angle negation and reduction to the CORDIC convergence range, one register stage.
// Depends on ezr_pkg.
`default_nettype none
module ezr_reduce
  import ezr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = AngleFracBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [2:0][15:0]  angle_i,
  input  wire logic              rate_i,
  output logic                   vld_o,
  output item_t                  item_o
);

  localparam int ZW   = (47 - ANGLE_FRAC_BITS > CW) ? 47 - ANGLE_FRAC_BITS : CW;
  localparam int NRed = (ANGLE_FRAC_BITS < 13) ? 13 - ANGLE_FRAC_BITS : 0;

  logic  vld_q;
  item_t item_q, item_d;

  always_comb begin
    logic signed [ZW-1:0] z, m;
    q_t                   r;
    logic                 fl;
    item_d.rate = rate_i;
    for (int l = 0; l < 3; l++) begin
      z = -(ZW'($signed(angle_i[l])) <<< (QFrac - ANGLE_FRAC_BITS));
      m = z[ZW-1] ? -z : z;
      for (int j = NRed - 1; j >= 0; j--) begin
        if (m >= (ZW'(QTwoPi) <<< j)) begin
          m = m - (ZW'(QTwoPi) <<< j);
        end
      end
      r = q_t'(m);
      if (r > QPi) begin
        r = r - QTwoPi;
      end
      if (z[ZW-1]) begin
        r = -r;
      end
      fl = 1'b0;
      if (r > QHalfPi) begin
        r  = r - QPi;
        fl = 1'b1;
      end else if (r < -QHalfPi) begin
        r  = r + QPi;
        fl = 1'b1;
      end
      item_d.lane[l].x    = QGain;
      item_d.lane[l].y    = '0;
      item_d.lane[l].z    = r;
      item_d.lane[l].flip = fl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

[sv/ezr_cordic_cell.sv]
// One CORDIC rotation step for all three angle lanes, registered.
// Depends on ezr_pkg.
`default_nettype none
module ezr_cordic_cell
  import ezr_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  vld_i,
  input  wire item_t item_i,
  output logic       vld_o,
  output item_t      item_o
);

  logic  vld_q;
  item_t item_q, item_d;

  always_comb begin
    q_t xs, ys;
    item_d = item_i;
    for (int l = 0; l < 3; l++) begin
      xs = item_i.lane[l].x >>> STAGE;
      ys = item_i.lane[l].y >>> STAGE;
      if (!item_i.lane[l].z[CW-1]) begin
        item_d.lane[l].x = item_i.lane[l].x - ys;
        item_d.lane[l].y = item_i.lane[l].y + xs;
        item_d.lane[l].z = item_i.lane[l].z - atan_q30(STAGE);
      end else begin
        item_d.lane[l].x = item_i.lane[l].x + ys;
        item_d.lane[l].y = item_i.lane[l].y - xs;
        item_d.lane[l].z = item_i.lane[l].z + atan_q30(STAGE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule
`default_nettype wire

[sv/ezr_product.sv]
// Two product stages that form the rotation and rate matrix entries in Q30.
// Depends on ezr_pkg.
`default_nettype none
module ezr_product
  import ezr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en1_i,
  input  wire logic  en2_i,
  input  wire logic  vld_i,
  input  wire item_t item_i,
  output logic       vld1_o,
  output logic       vld2_o,
  output mat_t       ent_o,
  output logic       rate_o
);

  logic vld1_q, vld2_q, rate1_q, rate2_q;
  q_t   czcy_q, szcx_q, szsx_q, czcx_q, czsx_q, szcy_q, cysx_q, cycx_q, cycz_q, cysz_q;
  q_t   czsy_q, szsy_q, sz_q, cz_q, sy_q, cx_q, sx_q;
  q_t   cz, sz, cy, sy, cx, sx;
  mat_t ent_q, ent_d;

  always_comb begin
    cz = item_i.lane[0].flip ? -item_i.lane[0].x : item_i.lane[0].x;
    sz = item_i.lane[0].flip ? -item_i.lane[0].y : item_i.lane[0].y;
    cy = item_i.lane[1].flip ? -item_i.lane[1].x : item_i.lane[1].x;
    sy = item_i.lane[1].flip ? -item_i.lane[1].y : item_i.lane[1].y;
    cx = item_i.lane[2].flip ? -item_i.lane[2].x : item_i.lane[2].x;
    sx = item_i.lane[2].flip ? -item_i.lane[2].y : item_i.lane[2].y;
  end

  always_comb begin
    ent_d[0]  = czcy_q;
    ent_d[1]  = -szcx_q + qmul(czsy_q, sx_q);
    ent_d[2]  = szsx_q + qmul(czsy_q, cx_q);
    ent_d[3]  = szcy_q;
    ent_d[4]  = czcx_q + qmul(szsy_q, sx_q);
    ent_d[5]  = -czsx_q + qmul(szsy_q, cx_q);
    ent_d[6]  = -sy_q;
    ent_d[7]  = cysx_q;
    ent_d[8]  = cycx_q;
    ent_d[9]  = '0;
    ent_d[10] = -sz_q;
    ent_d[11] = cycz_q;
    ent_d[12] = '0;
    ent_d[13] = cz_q;
    ent_d[14] = cysz_q;
    ent_d[15] = QOne;
    ent_d[16] = '0;
    ent_d[17] = -sy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (en1_i) begin
        vld1_q <= vld_i;
      end
      if (en2_i) begin
        vld2_q <= vld1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      czcy_q  <= qmul(cz, cy);
      szcx_q  <= qmul(sz, cx);
      szsx_q  <= qmul(sz, sx);
      czcx_q  <= qmul(cz, cx);
      czsx_q  <= qmul(cz, sx);
      szcy_q  <= qmul(sz, cy);
      cysx_q  <= qmul(cy, sx);
      cycx_q  <= qmul(cy, cx);
      cycz_q  <= qmul(cy, cz);
      cysz_q  <= qmul(cy, sz);
      czsy_q  <= qmul(cz, sy);
      szsy_q  <= qmul(sz, sy);
      sz_q    <= sz;
      cz_q    <= cz;
      sy_q    <= sy;
      cx_q    <= cx;
      sx_q    <= sx;
      rate1_q <= item_i.rate;
    end
    if (en2_i) begin
      ent_q   <= ent_d;
      rate2_q <= rate1_q;
    end
  end

  assign vld1_o = vld1_q;
  assign vld2_o = vld2_q;
  assign ent_o  = ent_q;
  assign rate_o = rate2_q;

endmodule
`default_nettype wire

[sv/euler_zyx_to_rotation_matrix_core.sv]
// Each accepted transaction carries yaw, pitch and roll; the core returns the three rows of the
// ZYX rotation matrix and, when the tuser flag is set, the three rows of the angle-rate matrix,
// one row per transaction on the master side in Q(OUT_FRAC_BITS). The single result register
// emits one row per cycle while m_axis_tready is high, three rows per input or six with the rate
// matrix; the stages ahead of it keep accepting into empty slots while rows wait to be taken.
// Depends on ezr_pkg, ezr_reduce, ezr_cordic_cell and ezr_product.
`default_nettype none
module euler_zyx_to_rotation_matrix_core
  import ezr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = AngleFracBits,
  parameter int OUT_FRAC_BITS   = OutFracBits,
  parameter int CORDIC_STAGES   = CordicStages
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // yaw_angle, pitch_angle, roll_angle
  input  wire logic        s_axis_tuser,  // want_rate_matrix
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // row_index, entry_col0, entry_col1, entry_col2
  output logic             m_axis_tuser,  // which_matrix
  output logic             m_axis_tlast   // last_row
);

  localparam int NSt = CORDIC_STAGES + 3;
  localparam int Sh  = QFrac - OUT_FRAC_BITS;

  logic [NSt:0]   en;
  logic [NSt-1:0] vld;
  item_t          item [CORDIC_STAGES+1];
  mat_t           ent_p, ent_q;
  logic           rate_p, rate_q, valid_q, last;
  logic [2:0]     cnt_q;
  q_t             col [3];
  logic [15:0]    out [3];

  for (genvar k = 0; k < NSt; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign en[NSt]       = !valid_q || (m_axis_tready && last);
  assign s_axis_tready = en[0];

  ezr_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[0]),
    .vld_i  (s_axis_tvalid),
    .angle_i({s_axis_tdata[47:32], s_axis_tdata[31:16], s_axis_tdata[15:0]}),
    .rate_i (s_axis_tuser),
    .vld_o  (vld[0]),
    .item_o (item[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    ezr_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en[k+1]),
      .vld_i (vld[k]),
      .item_i(item[k]),
      .vld_o (vld[k+1]),
      .item_o(item[k+1])
    );
  end

  ezr_product u_product (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en1_i (en[CORDIC_STAGES+1]),
    .en2_i (en[CORDIC_STAGES+2]),
    .vld_i (vld[CORDIC_STAGES]),
    .item_i(item[CORDIC_STAGES]),
    .vld1_o(vld[CORDIC_STAGES+1]),
    .vld2_o(vld[CORDIC_STAGES+2]),
    .ent_o (ent_p),
    .rate_o(rate_p)
  );

  assign last = rate_q ? (cnt_q == 3'd5) : (cnt_q == 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (en[NSt]) begin
      valid_q <= vld[NSt-1];
      cnt_q   <= '0;
    end else if (m_axis_tready) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSt]) begin
      ent_q  <= ent_p;
      rate_q <= rate_p;
    end
  end

  always_comb begin
    case (cnt_q)
      3'd0:    begin col[0] = ent_q[0];  col[1] = ent_q[1];  col[2] = ent_q[2];  end
      3'd1:    begin col[0] = ent_q[3];  col[1] = ent_q[4];  col[2] = ent_q[5];  end
      3'd2:    begin col[0] = ent_q[6];  col[1] = ent_q[7];  col[2] = ent_q[8];  end
      3'd3:    begin col[0] = ent_q[9];  col[1] = ent_q[10]; col[2] = ent_q[11]; end
      3'd4:    begin col[0] = ent_q[12]; col[1] = ent_q[13]; col[2] = ent_q[14]; end
      3'd5:    begin col[0] = ent_q[15]; col[1] = ent_q[16]; col[2] = ent_q[17]; end
      default: begin col[0] = '0;        col[1] = '0;        col[2] = '0;        end
    endcase
  end

  always_comb begin
    logic signed [CW:0] s, lim;
    lim = (36'sd1 <<< OUT_FRAC_BITS);
    for (int c = 0; c < 3; c++) begin
      s = (CW+1)'(col[c]) + ((36'sd1 <<< Sh) >>> 1);
      s = s >>> Sh;
      if (s > lim) begin
        s = lim;
      end
      if (s < -lim) begin
        s = -lim;
      end
      out[c] = s[15:0];
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = (cnt_q >= 3'd3);
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {6'd0, out[2], out[1], out[0],
                          (cnt_q >= 3'd3) ? 2'(cnt_q - 3'd3) : cnt_q[1:0]};

endmodule
`default_nettype wire

[test/euler_zyx_to_rotation_matrix_core_tb.sv]
// Testbench for euler_zyx_to_rotation_matrix_core: drives angle triples, predicts the rotation
// and angle-rate rows with a local CORDIC model and checks every result row in order.
// Depends on ezr_pkg and the core.
`default_nettype none

class ezr_row_board;
  typedef struct {
    logic        mat;
    logic [1:0]  row;
    logic [15:0] c0, c1, c2;
    logic        last;
  } row_t;

  row_t rows_pending[$];
  int   errors;

  static function longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  static function longint qprod(longint a, longint b);
    return floor_shr(a * b + (longint'(1) << 29), 30);
  endfunction

  static function logic [15:0] to_q14(longint v);
    longint r;
    r = floor_shr(v + (longint'(1) << 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  static function void neg_trig(logic [15:0] raw, output longint c, output longint s);
    longint z, x, y, k, xs, ys, t;
    bit     flip;
    z = -longint'($signed(raw)) * (longint'(1) << 17);
    x = ezr_pkg::QGain;
    y = 0;
    flip = 0;
    k = z / longint'(ezr_pkg::QTwoPi);
    z -= k * longint'(ezr_pkg::QTwoPi);
    if (z > longint'(ezr_pkg::QPi)) z -= longint'(ezr_pkg::QTwoPi);
    if (z < -longint'(ezr_pkg::QPi)) z += longint'(ezr_pkg::QTwoPi);
    if (z > longint'(ezr_pkg::QHalfPi)) begin
      z -= longint'(ezr_pkg::QPi);
      flip = 1;
    end else if (z < -longint'(ezr_pkg::QHalfPi)) begin
      z += longint'(ezr_pkg::QPi);
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      case (i)
        0: t = 'h3243F6A8;  1: t = 'h1DAC6705;  2: t = 'h0FADBAFC;  3: t = 'h07F56EA6;
        4: t = 'h03FEAB76;  5: t = 'h01FFD55B;  6: t = 'h00FFFAAA;  7: t = 'h007FFF55;
        8: t = 'h003FFFEA;  9: t = 'h001FFFFD; 10: t = 'h000FFFFF; 11: t = 'h0007FFFF;
        12: t = 'h0003FFFF; 13: t = 'h0001FFFF; 14: t = 'h0000FFFF; default: t = 'h00007FFF;
      endcase
      if (z >= 0) begin
        x -= ys; y += xs; z -= t;
      end else begin
        x += ys; y -= xs; z += t;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void push_row(logic m, logic [1:0] r, longint a, longint b, longint c, logic l);
    row_t e;
    e.mat = m; e.row = r; e.c0 = to_q14(a); e.c1 = to_q14(b); e.c2 = to_q14(c); e.last = l;
    rows_pending.push_back(e);
  endfunction

  function void note_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll,
                            logic rate);
    longint cz, sz, cy, sy, cx, sx, czsy, szsy;
    neg_trig(yaw, cz, sz);
    neg_trig(pitch, cy, sy);
    neg_trig(roll, cx, sx);
    czsy = qprod(cz, sy);
    szsy = qprod(sz, sy);
    push_row(0, 0, qprod(cz, cy), -qprod(sz, cx) + qprod(czsy, sx),
             qprod(sz, sx) + qprod(czsy, cx), 0);
    push_row(0, 1, qprod(sz, cy), qprod(cz, cx) + qprod(szsy, sx),
             -qprod(cz, sx) + qprod(szsy, cx), 0);
    push_row(0, 2, -sy, qprod(cy, sx), qprod(cy, cx), !rate);
    if (rate) begin
      push_row(1, 0, 0, -sz, qprod(cy, cz), 0);
      push_row(1, 1, 0, cz, qprod(cy, sz), 0);
      push_row(1, 2, longint'(1) << 30, 0, -sy, 1);
    end
  endfunction

  task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task check_row(logic [55:0] data, logic mat, logic last);
    row_t e;
    if (rows_pending.size() == 0) begin
      $display("unexpected row %h", data);
      errors++;
      return;
    end
    e = rows_pending.pop_front();
    if (mat !== e.mat) report_mismatch("which_matrix", 16'(mat), 16'(e.mat));
    if (data[1:0] !== e.row) report_mismatch("row_index", 16'(data[1:0]), 16'(e.row));
    if (data[17:2] !== e.c0) report_mismatch("entry_col0", data[17:2], e.c0);
    if (data[33:18] !== e.c1) report_mismatch("entry_col1", data[33:18], e.c1);
    if (data[49:34] !== e.c2) report_mismatch("entry_col2", data[49:34], e.c2);
    if (last !== e.last) report_mismatch("last_row", 16'(last), 16'(e.last));
  endtask
endclass

module euler_zyx_to_rotation_matrix_core_tb;
  import ezr_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser, m_axis_tlast;
  logic [55:0] m_axis_tdata;

  ezr_row_board board;
  int           send_idle_pct, recv_stall_pct;

  euler_zyx_to_rotation_matrix_core dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_row(m_axis_tdata, m_axis_tuser, m_axis_tlast);

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);

  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll,
                             logic rate);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {roll, pitch, yaw};
    s_axis_tuser  <= rate;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_angles(yaw, pitch, roll, rate);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] any_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3)) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(51472)) - 25736);
    endcase
  endfunction

  logic [15:0] edge_vals[10] = '{16'h0000, 16'h6488, 16'h9B78, 16'h7FFF, 16'h8000,
                                 16'h3244, 16'hCDBC, 16'h6487, 16'h0001, 16'hFFFF};

  initial begin
    board = new();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    for (int i = 0; i < 20; i++)
      send_angles(edge_vals[i % 10], edge_vals[(i * 3 + 1) % 10], edge_vals[(i * 7 + 2) % 10],
                  i[0]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 23) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 72 : 23) : 0;
      for (int i = 0; i < 105; i++)
        send_angles(any_angle(), any_angle(), any_angle(), 1'($urandom));
    end
    s_axis_tvalid <= 0;
    recv_stall_pct = 0;
    while (board.rows_pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.errors == 0 && board.rows_pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
